FILE: src/huffman_tree_build_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Huffman tree build decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_BUILD_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_BUILD_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define HTBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HTBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/htbd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree build decoder package
// Request codes, register map, widths and shared types.
// ----------------------------------------------------------------------------
package htbd_pkg;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_BUILD  = 2'd1;
  localparam logic [1:0] MODE_DECODE = 2'd2;

  localparam logic       REG_MAX_OUTPUT   = 1'b0;
  localparam int         WEIGHT_W         = 17;
  localparam logic [15:0] MAX_OUTPUT_RESET = 16'hFFFF;

  localparam logic       KIND_BUILD  = 1'b0;
  localparam logic       KIND_DECODE = 1'b1;

  typedef struct packed {
    logic clr;  // restart the minimum search
    logic en;   // present one weight to the search
  } scan_ctl_t;

endpackage

FILE: src/htbd_ram.sv
// ----------------------------------------------------------------------------
// Huffman tree build decoder RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module htbd_ram #(
  parameter int DW    = 17,
  parameter int DEPTH = 513,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/htbd_min_scan.sv
// ----------------------------------------------------------------------------
// Huffman tree build decoder minimum search
// Tracks the two least nonzero weights over an ascending scan.
// ----------------------------------------------------------------------------
module htbd_min_scan #(
  parameter int IW = 10
) (
  input  logic                         clk,
  input  htbd_pkg::scan_ctl_t          ctl,
  input  logic [IW-1:0]                idx,
  input  logic [htbd_pkg::WEIGHT_W-1:0] w,
  output logic                         have1,
  output logic                         have2,
  output logic [IW-1:0]                m1,
  output logic [IW-1:0]                m2,
  output logic [htbd_pkg::WEIGHT_W-1:0] w1,
  output logic [htbd_pkg::WEIGHT_W-1:0] w2
);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      have1 <= 1'b0;
      have2 <= 1'b0;
    end else if (ctl.en && (w != '0)) begin
      // strict less-than: lower index wins ties
      if (!have1 || (w < w1)) begin
        m2    <= m1;
        w2    <= w1;
        have2 <= have1;
        m1    <= idx;
        w1    <= w;
        have1 <= 1'b1;
      end else if (!have2 || (w < w2)) begin
        m2    <= idx;
        w2    <= w;
        have2 <= 1'b1;
      end
    end
  end

endmodule

FILE: src/huffman_tree_build_decoder_unit.sv
// ----------------------------------------------------------------------------
// Huffman tree build decoder unit
// Loads symbol counts, builds a Huffman tree on chip and decodes bit by bit.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                              Handshake
//  --------  -------------------------------------------------  -------------
//  request   mode symbol_index symbol_count code_bit            start / busy
//  result    result_kind root_node decoded_symbol
//            stream_end limit_reached                           done strobe
//  config    psel penable pwrite paddr pwdata prdata pready     APB, no wait
//
//  A load writes straight from idle; a decode bit makes one child-table read.
//  A build first writes the end-of-stream weight, then per merge scans the
//  weights of all current nodes (one read per node, a compare of the last read,
//  a decision) and makes three writes on the single weight RAM write port.
//  After rst a clearing pass zeroes all 2*NUM_SYMBOLS+1 weight RAM entries;
//  busy stays high meanwhile. Results show for one cycle on done; the
//  receiver cannot stall them.
// ----------------------------------------------------------------------------
`include "huffman_tree_build_decoder_unit_defines.svh"

module huffman_tree_build_decoder_unit #(
  parameter int NUM_SYMBOLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  symbol_index,
  input  logic [7:0]  symbol_count,
  input  logic        code_bit,
  output logic        done,
  output logic        result_kind,
  output logic [9:0]  root_node,
  output logic [7:0]  decoded_symbol,
  output logic        stream_end,
  output logic        limit_reached,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOTS = 2 * NUM_SYMBOLS + 1;
  localparam int IW    = $clog2(SLOTS + 1);
  localparam int WW    = htbd_pkg::WEIGHT_W;
  localparam logic [IW-1:0] EOS_IDX   = IW'(NUM_SYMBOLS);
  localparam logic [IW-1:0] SLOTS_IDX = IW'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EOS, ST_SCAN, ST_MERGE, ST_ZERO_M1, ST_ZERO_M2, ST_DECODE
  } state_t;

  state_t        state;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] next_node;
  logic          pend_valid;
  logic [IW-1:0] pend_idx;
  logic [IW-1:0] tree_root;
  logic [IW-1:0] walk_node;
  logic [15:0]   emitted_count;
  logic          session_over;
  logic          bit_reg;
  logic [15:0]   max_cnt;

  logic          accept;
  logic          cfg_write;
  logic          w_we;
  logic [IW-1:0] w_waddr;
  logic [WW-1:0] w_wdata;
  logic [IW-1:0] w_raddr;
  logic [WW-1:0] w_rdata;
  logic [2*IW-1:0] c_rdata;
  logic          have1;
  logic          have2;
  logic [IW-1:0] m1;
  logic [IW-1:0] m2;
  logic [WW-1:0] w1;
  logic [WW-1:0] w2;
  htbd_pkg::scan_ctl_t scan_ctl;

  logic          walk_internal;
  logic [IW-1:0] child;
  logic [IW-1:0] node_hit;
  logic [15:0]   emitted_next;
  logic          scan_done;
  logic [IW-1:0] next_inc;

  logic          res_build;
  logic          res_decode;
  logic          root_ok;
  logic          build_req;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == htbd_pkg::REG_MAX_OUTPUT) ? {16'd0, max_cnt} : 32'd0;

  // Weight RAM port steering
  always_comb begin
    w_we    = 1'b0;
    w_waddr = scan_idx;
    w_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        w_we = 1'b1;
      end
      ST_IDLE: begin
        w_we    = accept && (mode == htbd_pkg::MODE_LOAD) &&
                  ({1'b0, symbol_index} < 9'(NUM_SYMBOLS));
        w_waddr = IW'(symbol_index);
        w_wdata = WW'(symbol_count);
      end
      ST_EOS: begin
        w_we    = 1'b1;
        w_waddr = EOS_IDX;
        w_wdata = WW'(1);
      end
      ST_MERGE: begin
        w_we    = 1'b1;
        w_waddr = next_node;
        w_wdata = w1 + w2;
      end
      ST_ZERO_M1: begin
        w_we    = 1'b1;
        w_waddr = m1;
      end
      ST_ZERO_M2: begin
        w_we    = 1'b1;
        w_waddr = m2;
      end
      default: begin
        w_we = 1'b0;
      end
    endcase
  end

  assign w_raddr      = scan_idx;
  assign scan_ctl.clr = (state == ST_EOS) || (state == ST_ZERO_M2);
  assign scan_ctl.en  = (state == ST_SCAN) && pend_valid;
  assign scan_done    = (scan_idx == next_node) && !pend_valid;
  assign next_inc     = next_node + 1'b1;

  // Decode step: leaves and out-of-range nodes lead to end of stream
  assign walk_internal = (walk_node > EOS_IDX) && (walk_node < SLOTS_IDX);
  assign child         = bit_reg ? c_rdata[2*IW-1:IW] : c_rdata[IW-1:0];
  always_comb begin
    node_hit = walk_internal ? child : EOS_IDX;
    if (node_hit >= SLOTS_IDX) begin
      node_hit = EOS_IDX;
    end
  end
  assign emitted_next = emitted_count + 16'd1;

  htbd_ram #(.DW(WW), .DEPTH(SLOTS), .AW(IW)) u_weight (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  htbd_ram #(.DW(2 * IW), .DEPTH(SLOTS), .AW(IW)) u_child (
    .clk   (clk),
    .we    (state == ST_MERGE),
    .waddr (next_node),
    .wdata ({m2, m1}),
    .raddr (walk_node),
    .rdata (c_rdata)
  );

  htbd_min_scan #(.IW(IW)) u_scan (
    .clk   (clk),
    .ctl   (scan_ctl),
    .idx   (pend_idx),
    .w     (w_rdata),
    .have1 (have1),
    .have2 (have2),
    .m1    (m1),
    .m2    (m2),
    .w1    (w1),
    .w2    (w2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      scan_idx      <= '0;
      next_node     <= '0;
      pend_valid    <= 1'b0;
      tree_root     <= '0;
      walk_node     <= '0;
      emitted_count <= '0;
      session_over  <= 1'b0;
      max_cnt       <= htbd_pkg::MAX_OUTPUT_RESET;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write && (paddr[2] == htbd_pkg::REG_MAX_OUTPUT)) begin
        max_cnt <= pwdata[15:0];
      end
      unique case (state)
        ST_CLEAR: begin
          // sweep the weight RAM to zero
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            bit_reg <= code_bit;
            if (mode == htbd_pkg::MODE_BUILD) begin
              state <= ST_EOS;
            end else if ((mode == htbd_pkg::MODE_DECODE) && !session_over) begin
              state <= ST_DECODE;
            end
          end
        end
        ST_EOS: begin
          next_node  <= EOS_IDX + 1'b1;
          scan_idx   <= '0;
          pend_valid <= 1'b0;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          // issue one read per cycle; compare the previous read
          if (scan_idx != next_node) begin
            pend_valid <= 1'b1;
            pend_idx   <= scan_idx;
            scan_idx   <= scan_idx + 1'b1;
          end else begin
            pend_valid <= 1'b0;
          end
          if (scan_done) begin
            if (have2) begin
              state <= ST_MERGE;
            end else begin
              tree_root      <= next_node - 1'b1;
              walk_node      <= next_node - 1'b1;
              emitted_count  <= '0;
              session_over   <= 1'b0;
              done           <= 1'b1;
              result_kind    <= htbd_pkg::KIND_BUILD;
              root_node      <= 10'(next_node - 1'b1);
              decoded_symbol <= '0;
              stream_end     <= 1'b0;
              limit_reached  <= 1'b0;
              state          <= ST_IDLE;
            end
          end
        end
        ST_MERGE: begin
          state <= ST_ZERO_M1;
        end
        ST_ZERO_M1: begin
          state <= ST_ZERO_M2;
        end
        ST_ZERO_M2: begin
          next_node  <= next_inc;
          scan_idx   <= '0;
          pend_valid <= 1'b0;
          if (next_inc == SLOTS_IDX) begin
            tree_root      <= next_node;
            walk_node      <= next_node;
            emitted_count  <= '0;
            session_over   <= 1'b0;
            done           <= 1'b1;
            result_kind    <= htbd_pkg::KIND_BUILD;
            root_node      <= 10'(next_node);
            decoded_symbol <= '0;
            stream_end     <= 1'b0;
            limit_reached  <= 1'b0;
            state          <= ST_IDLE;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_DECODE: begin
          state <= ST_IDLE;
          if ((node_hit > EOS_IDX) && (node_hit < SLOTS_IDX)) begin
            // advance down the tree
            walk_node <= node_hit;
          end else begin
            walk_node      <= tree_root;
            done           <= 1'b1;
            result_kind    <= htbd_pkg::KIND_DECODE;
            root_node      <= '0;
            if (node_hit == EOS_IDX) begin
              decoded_symbol <= '0;
              stream_end     <= 1'b1;
              limit_reached  <= 1'b0;
              session_over   <= 1'b1;
            end else begin
              decoded_symbol <= 8'(node_hit);
              stream_end     <= 1'b0;
              emitted_count  <= emitted_next;
              limit_reached  <= (emitted_next >= max_cnt);
              session_over   <= (emitted_next >= max_cnt);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_build  = done && (result_kind == htbd_pkg::KIND_BUILD);
  assign res_decode = done && (result_kind == htbd_pkg::KIND_DECODE);
  assign root_ok    = (root_node >= 10'(NUM_SYMBOLS)) && (root_node < 10'(SLOTS));
  assign build_req  = accept && (mode == htbd_pkg::MODE_BUILD);

  `HTBD_ASSERT_NOW(a_root_range, res_build, root_ok, "build root out of range")
  `HTBD_ASSERT_NEXT(a_build_busy, build_req, busy, "build request did not raise busy")
  `HTBD_ASSERT_NOW(a_one_flag, res_decode, !(stream_end && limit_reached), "both end flags set")
  `HTBD_ASSERT_NOW(a_clear_quiet, state == ST_CLEAR, !done, "result during clearing pass")

endmodule
